>>> rtl/core/bfc_pkg.sv
// Shared types and constants for the box frustum cull test block.
`default_nettype none
package bfc_pkg;

  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CMP_W     = SUM_W + 1;
  localparam int N_WORDS   = 6;
  localparam int N_ROWS    = 4;
  localparam int N_MULS    = 3;
  localparam int CORNERS   = 8;
  localparam int CORNER_W  = 3;
  localparam int Q_DEPTH   = 2;
  localparam int CODE_W    = 6;

  localparam logic [2:0] KIND_TEST = 3'd4;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_TEST   = 2'd1;
  localparam logic [1:0] OP_HIDDEN = 2'd2;
  localparam logic [1:0] OP_SHOW   = 2'd3;

  localparam logic [1:0] VERDICT_SKIP    = 2'd0;
  localparam logic [1:0] VERDICT_VISIBLE = 2'd1;
  localparam logic [1:0] VERDICT_CULLED  = 2'd2;

  localparam logic [CODE_W-1:0] CODE_X_HI = 6'h01;
  localparam logic [CODE_W-1:0] CODE_X_LO = 6'h02;
  localparam logic [CODE_W-1:0] CODE_Y_HI = 6'h04;
  localparam logic [CODE_W-1:0] CODE_Y_LO = 6'h08;
  localparam logic [CODE_W-1:0] CODE_Z_LO = 6'h10;
  localparam logic [CODE_W-1:0] CODE_Z_HI = 6'h20;
  localparam logic [CODE_W-1:0] CODE_ALL  = 6'h3F;

  localparam int W_MIN_X = 0;
  localparam int W_MIN_Y = 1;
  localparam int W_MIN_Z = 2;
  localparam int W_MAX_X = 3;
  localparam int W_MAX_Y = 4;
  localparam int W_MAX_Z = 5;

  typedef struct packed {
    logic [1:0]                     op;
    logic [1:0]                     row;
    logic [N_WORDS-1:0][DATA_W-1:0] data;
  } q_entry_t;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       fixed;
    logic [1:0] verdict;
  } stage_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/box_frustum_cull_test.sv
// Top level of the box frustum cull test block.
// Items of kind 0 to 3 load one row of the local-to-clip matrix; kind 4 tests
// a box and gives one result, kinds 5 to 7 are dropped. A box test runs its
// eight corners one per cycle, while no waiting result stalls the back end,
// through twelve 32x32 multipliers; row writes and hidden or never-cull items
// issue once each. A result passes stage 1, stage 2 and the result register
// after its last corner issues. A two-entry queue takes input while a result
// waits. Matrix entries read as undefined until their row has been written.
`default_nettype none
module box_frustum_cull_test
  import bfc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // entry_a, entry_b, entry_c, entry_d, min_x, min_y, min_z, max_x, max_y, max_z
  input  wire logic [319:0] in_tdata,
  // kind, bypass
  input  wire logic [4:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // verdict, clip_and
  output logic [7:0]        out_tdata
);

  logic     q_full, q_push, q_head_valid, q_pop;
  q_entry_t q_wdata, q_head;

  bfc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  bfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  bfc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

>>> rtl/core/bfc_front.sv
// Front end: accept input transactions, classify them and pack queue entries.
`default_nettype none
module bfc_front
  import bfc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [319:0] in_tdata,
  input  wire logic [4:0]   in_tuser,
  input  wire logic         q_full,
  output logic              q_push,
  output q_entry_t          q_wdata
);

  logic [2:0] kind;
  logic [1:0] bypass;
  logic       take_r;

  assign kind      = in_tuser[2:0];
  assign bypass    = in_tuser[4:3];
  assign in_tready = !q_full && take_r;

  // hold off acceptance until reset has been released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_r <= 1'b0;
    end else begin
      take_r <= 1'b1;
    end
  end

  always_comb begin
    q_push       = in_tvalid && in_tready && (kind <= KIND_TEST);
    q_wdata.row  = kind[1:0];
    q_wdata.data = '0;
    q_wdata.op   = OP_WRITE;
    if (kind == KIND_TEST) begin
      if (bypass[0]) begin
        q_wdata.op = OP_HIDDEN;
      end else if (bypass[1]) begin
        q_wdata.op = OP_SHOW;
      end else begin
        q_wdata.op = OP_TEST;
      end
      q_wdata.data[W_MIN_X] = in_tdata[159:128];
      q_wdata.data[W_MIN_Y] = in_tdata[191:160];
      q_wdata.data[W_MIN_Z] = in_tdata[223:192];
      q_wdata.data[W_MAX_X] = in_tdata[255:224];
      q_wdata.data[W_MAX_Y] = in_tdata[287:256];
      q_wdata.data[W_MAX_Z] = in_tdata[319:288];
    end else begin
      q_wdata.data[0] = in_tdata[31:0];
      q_wdata.data[1] = in_tdata[63:32];
      q_wdata.data[2] = in_tdata[95:64];
      q_wdata.data[3] = in_tdata[127:96];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bfc_queue.sv
// Short queue between the front end and the transform back end.
`default_nettype none
module bfc_queue
  import bfc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire q_entry_t wdata,
  output logic          full,
  output logic          head_valid,
  output q_entry_t      head,
  input  wire logic     pop
);

  localparam int PTR_W = $clog2(Q_DEPTH);

  q_entry_t         mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [PTR_W:0]   count_r;

  assign full       = (count_r == (PTR_W+1)'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bfc_back.sv
// Back end: matrix store, corner transform pipeline, outcode AND and result register.
`default_nettype none
module bfc_back
  import bfc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     head_valid,
  input  wire q_entry_t head,
  output logic          pop,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output logic [7:0]    out_tdata
);

  logic [DATA_W-1:0]        mat_r [N_ROWS][N_ROWS];
  logic [CORNER_W-1:0]      cnt_r;
  stage_ctl_t               issue_ctl, s1_ctl_r, s2_ctl_r;
  logic signed [PROD_W-1:0] s1_prod_r [N_ROWS][N_MULS];
  logic signed [SUM_W-1:0]  s1_dterm_r [N_ROWS];
  logic signed [SUM_W-1:0]  s2_sum_r [N_ROWS];
  logic signed [DATA_W-1:0] cx, cy, cz;
  logic [CODE_W-1:0]        acc_r, acc_nxt, code;
  logic                     out_valid_r;
  logic [1:0]               out_verdict_r;
  logic [CODE_W-1:0]        out_clip_r;
  logic                     adv, issue, last_issue, out_free;
  logic signed [CMP_W-1:0]  x_sum, x_dif, y_sum, y_dif, z_dif, z_ext;

  assign out_free   = !out_valid_r || out_tready;
  assign adv        = !(s2_ctl_r.valid && s2_ctl_r.last && !out_free);
  assign issue      = head_valid && adv;
  assign last_issue = (head.op != OP_TEST) || (cnt_r == CORNER_W'(CORNERS - 1));
  assign pop        = issue && last_issue;

  assign cx = cnt_r[2] ? $signed(head.data[W_MAX_X]) : $signed(head.data[W_MIN_X]);
  assign cy = cnt_r[1] ? $signed(head.data[W_MAX_Y]) : $signed(head.data[W_MIN_Y]);
  assign cz = cnt_r[0] ? $signed(head.data[W_MAX_Z]) : $signed(head.data[W_MIN_Z]);

  always_comb begin
    issue_ctl.valid   = issue && (head.op != OP_WRITE);
    issue_ctl.first   = (cnt_r == '0);
    issue_ctl.last    = last_issue;
    issue_ctl.fixed   = (head.op != OP_TEST);
    issue_ctl.verdict = (head.op == OP_HIDDEN) ? VERDICT_SKIP : VERDICT_VISIBLE;
  end

  // matrix rows, written in queue order
  always_ff @(posedge clk) begin
    if (issue && head.op == OP_WRITE) begin
      for (int c = 0; c < N_ROWS; c++) begin
        mat_r[head.row][c] <= head.data[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (issue && head.op == OP_TEST) begin
      cnt_r <= last_issue ? '0 : cnt_r + 1'b1;
    end
  end

  // stage 1: products of the current corner with every row, and the shifted translation terms
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < N_ROWS; r++) begin
        s1_prod_r[r][0] <= PROD_W'(cx * $signed(mat_r[r][0]));
        s1_prod_r[r][1] <= PROD_W'(cy * $signed(mat_r[r][1]));
        s1_prod_r[r][2] <= PROD_W'(cz * $signed(mat_r[r][2]));
        s1_dterm_r[r]   <= SUM_W'($signed(mat_r[r][3])) <<< FRAC_BITS;
      end
    end
  end

  // stage 2: exact row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < N_ROWS; r++) begin
        s2_sum_r[r] <= SUM_W'(s1_prod_r[r][0]) + SUM_W'(s1_prod_r[r][1])
                     + SUM_W'(s1_prod_r[r][2]) + s1_dterm_r[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= issue_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // stage 3: outcode of one corner, ANDed into the accumulated code
  always_comb begin
    x_sum = CMP_W'(s2_sum_r[0]) + CMP_W'(s2_sum_r[3]);
    x_dif = CMP_W'(s2_sum_r[0]) - CMP_W'(s2_sum_r[3]);
    y_sum = CMP_W'(s2_sum_r[1]) + CMP_W'(s2_sum_r[3]);
    y_dif = CMP_W'(s2_sum_r[1]) - CMP_W'(s2_sum_r[3]);
    z_dif = CMP_W'(s2_sum_r[2]) - CMP_W'(s2_sum_r[3]);
    z_ext = CMP_W'(s2_sum_r[2]);
    code  = '0;
    if (y_sum < 0) begin
      code = code | CODE_Y_LO;
    end else if (y_dif > 0) begin
      code = code | CODE_Y_HI;
    end
    if (z_dif > 0) begin
      code = code | CODE_Z_HI;
    end else if (z_ext < 0) begin
      code = code | CODE_Z_LO;
    end
    if (x_sum < 0) begin
      code = code | CODE_X_LO;
    end else if (x_dif > 0) begin
      code = code | CODE_X_HI;
    end
    acc_nxt = (s2_ctl_r.first ? CODE_ALL : acc_r) & code;
  end

  always_ff @(posedge clk) begin
    if (adv && s2_ctl_r.valid && !s2_ctl_r.fixed) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s2_ctl_r.valid && s2_ctl_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_ctl_r.valid && s2_ctl_r.last) begin
      if (s2_ctl_r.fixed) begin
        out_verdict_r <= s2_ctl_r.verdict;
        out_clip_r    <= '0;
      end else begin
        out_verdict_r <= (acc_nxt != '0) ? VERDICT_CULLED : VERDICT_VISIBLE;
        out_clip_r    <= acc_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_clip_r, out_verdict_r};

endmodule
`default_nettype wire
